// ===== hdl/gsm_pkg.sv =====
// ----------------------------------------------------------------------------
// gsm_pkg
// shared types and constants of the glob segment matcher
// ----------------------------------------------------------------------------
package gsm_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_NAME   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY     = 2'd1,
        KIND_CLASS   = 2'd2,
        KIND_STAR    = 2'd3
    } kind_t;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_status_t;

endpackage

// ===== hdl/glob_segment_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_segment_matcher
// glob pattern matcher with classes, one name byte per cycle
// ----------------------------------------------------------------------------
// channel  dir  tdata              tuser
// s_axis   in   byte_value [7:0]   command [1:0]
// m_axis   out  matched, overflow  -
//
// name bytes and end of name run at one transaction per cycle
// first name transaction after a pattern change waits for compile:
//   the pattern ram is read anew per token or class member, then all 256 class table entries are written
// a bracket with no close rescans its bytes once more
// no clearing pass after reset; a two-entry queue lets input and result stall apart
// ----------------------------------------------------------------------------
module glob_segment_matcher
    import gsm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // byte_value
    input  logic [1:0] s_axis_tuser,   // command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // matched, pattern_overflow, zero pad
);

    localparam int AW = $clog2(PATTERN_MAX);
    localparam int LW = $clog2(PATTERN_MAX+1);

    item_t             head;
    logic              head_valid;
    logic              pop;
    logic              cmp_start;
    cmp_status_t       cmp_status;
    logic [LW-1:0]     length;
    logic              pat_we;
    logic [AW-1:0]     pat_waddr;
    logic [7:0]        pat_wdata;
    kind_t             tok_kind [PATTERN_MAX];
    logic [7:0]        tok_lit [PATTERN_MAX];
    logic [LW-1:0]     tok_count;
    logic              cls_we;
    logic [7:0]        cls_waddr;
    logic [PATTERN_MAX-1:0] cls_wdata;

    gsm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop)
    );

    gsm_compiler #(.PM(PATTERN_MAX)) u_compiler (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmp_start),
        .length    (length),
        .pat_we    (pat_we),
        .pat_waddr (pat_waddr),
        .pat_wdata (pat_wdata),
        .status    (cmp_status),
        .tok_kind  (tok_kind),
        .tok_lit   (tok_lit),
        .tok_count (tok_count),
        .cls_we    (cls_we),
        .cls_waddr (cls_waddr),
        .cls_wdata (cls_wdata)
    );

    gsm_back #(.PM(PATTERN_MAX)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .cmp_start     (cmp_start),
        .cmp_status    (cmp_status),
        .length        (length),
        .pat_we        (pat_we),
        .pat_waddr     (pat_waddr),
        .pat_wdata     (pat_wdata),
        .tok_kind      (tok_kind),
        .tok_lit       (tok_lit),
        .tok_count     (tok_count),
        .cls_we        (cls_we),
        .cls_waddr     (cls_waddr),
        .cls_wdata     (cls_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/gsm_ram.sv =====
// ----------------------------------------------------------------------------
// gsm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module gsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/gsm_front.sv =====
// ----------------------------------------------------------------------------
// gsm_front
// accepts input transactions, decodes the command and queues them
// ----------------------------------------------------------------------------
module gsm_front
    import gsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic [1:0] s_axis_tuser,
    output item_t      head,
    output logic       head_valid,
    input  logic       pop
);

    item_t       mem_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       item_in;

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head_valid    = (cnt_reg != 2'd0);
    assign head          = mem_reg[rp_reg];

    always_comb
    begin
        item_in.cmd   = cmd_t'(s_axis_tuser);
        item_in.value = s_axis_tdata;
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/gsm_compiler.sv =====
// ----------------------------------------------------------------------------
// gsm_compiler
// turns the stored pattern into tokens and fills the byte class table
// ----------------------------------------------------------------------------
module gsm_compiler
    import gsm_pkg::*;
#(
    parameter int PM = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [$clog2(PM+1)-1:0] length,
    input  logic                    pat_we,
    input  logic [$clog2(PM)-1:0]   pat_waddr,
    input  logic [7:0]              pat_wdata,
    output cmp_status_t             status,
    output kind_t                   tok_kind [PM],
    output logic [7:0]              tok_lit [PM],
    output logic [$clog2(PM+1)-1:0] tok_count,
    output logic                    cls_we,
    output logic [7:0]              cls_waddr,
    output logic [PM-1:0]           cls_wdata
);

    localparam int AW = $clog2(PM);
    localparam int LW = $clog2(PM+1);
    localparam int IW = LW + 1;

    typedef enum logic [5:0] {
        C_IDLE  = 6'b000001,
        C_FETCH = 6'b000010,
        C_TOK   = 6'b000100,
        C_CNEG  = 6'b001000,
        C_CLS   = 6'b010000,
        C_SWEEP = 6'b100000
    } cstate_t;

    cstate_t         state_reg, state_next;
    cstate_t         ret_reg, ret_next;
    logic [IW-1:0]   base_reg, base_next;
    logic [1:0]      fcnt_reg, fcnt_next;
    logic [7:0]      w0_reg, w1_reg, w2_reg;
    logic [IW-1:0]   p_reg, p_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   cs_reg, cs_next;
    logic            neg_reg, neg_next;
    logic            first_reg, first_next;
    logic [LW-1:0]   dbase_reg, dbase_next;
    logic [LW-1:0]   dcount_reg, dcount_next;
    logic [LW-1:0]   count_reg, count_next;
    logic [7:0]      c_reg, c_next;
    kind_t           kind_reg [PM];
    logic [7:0]      lit_reg [PM];
    logic            negm_reg [PM];
    logic [7:0]      dlo_reg [PM];
    logic [7:0]      dhi_reg [PM];
    logic [AW-1:0]   down_reg [PM];

    logic            emit_en;
    kind_t           emit_kind;
    logic [7:0]      emit_lit;
    logic            emit_neg;
    logic            desc_en;
    logic [7:0]      desc_lo, desc_hi;
    logic            done;
    logic [IW:0]     faddr;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;
    logic [IW-1:0]   len_x;
    logic [PM-1:0]   word;
    logic [PM-1:0]   negm_vec;

    assign len_x = {1'b0, length};
    assign faddr = {1'b0, base_reg} + {{(IW-1){1'b0}}, fcnt_reg};
    assign raddr = (faddr < (IW+1)'(PM)) ? faddr[AW-1:0] : '0;

    gsm_ram #(.WIDTH(8), .DEPTH(PM)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // membership word of the swept byte over all class tokens
    always_comb
    begin
        word = '0;
        for (int d = 0; d < PM; d++)
        begin
            negm_vec[d] = negm_reg[d];
            if ((LW'(d) < dcount_reg) && (dlo_reg[d] <= c_reg) && (c_reg <= dhi_reg[d]))
            begin
                word[down_reg[d]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        base_next   = base_reg;
        fcnt_next   = fcnt_reg;
        p_next      = p_reg;
        i_next      = i_reg;
        cs_next     = cs_reg;
        neg_next    = neg_reg;
        first_next  = first_reg;
        dbase_next  = dbase_reg;
        dcount_next = dcount_reg;
        count_next  = count_reg;
        c_next      = c_reg;
        emit_en     = 1'b0;
        emit_kind   = KIND_LITERAL;
        emit_lit    = 8'd0;
        emit_neg    = 1'b0;
        desc_en     = 1'b0;
        desc_lo     = w0_reg;
        desc_hi     = w0_reg;
        done        = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    p_next      = '0;
                    count_next  = '0;
                    dcount_next = '0;
                    base_next   = '0;
                    fcnt_next   = 2'd0;
                    ret_next    = C_TOK;
                    state_next  = C_FETCH;
                end
            end
            C_FETCH:
            begin
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd3)
                begin
                    state_next = ret_reg;
                end
            end
            C_TOK:
            begin
                fcnt_next  = 2'd0;
                state_next = C_FETCH;
                ret_next   = C_TOK;
                if (p_reg >= len_x)
                begin
                    c_next     = 8'd0;
                    state_next = C_SWEEP;
                end
                else if (w0_reg == CH_LBRACK)
                begin
                    cs_next    = p_reg;
                    i_next     = p_reg + IW'(1);
                    neg_next   = 1'b0;
                    first_next = 1'b1;
                    dbase_next = dcount_reg;
                    base_next  = p_reg + IW'(1);
                    ret_next   = C_CNEG;
                end
                else
                begin
                    emit_en = 1'b1;
                    if (w0_reg == CH_STAR)
                    begin
                        emit_kind = KIND_STAR;
                    end
                    else if (w0_reg == CH_QUEST)
                    begin
                        emit_kind = KIND_ANY;
                    end
                    else
                    begin
                        emit_lit = w0_reg;
                    end
                    p_next    = p_reg + IW'(1);
                    base_next = p_reg + IW'(1);
                end
            end
            C_CNEG:
            begin
                if ((i_reg < len_x) && ((w0_reg == CH_BANG) || (w0_reg == CH_CARET)))
                begin
                    neg_next   = 1'b1;
                    i_next     = i_reg + IW'(1);
                    base_next  = i_reg + IW'(1);
                    fcnt_next  = 2'd0;
                    ret_next   = C_CLS;
                    state_next = C_FETCH;
                end
                else
                begin
                    state_next = C_CLS;
                end
            end
            C_CLS:
            begin
                fcnt_next  = 2'd0;
                state_next = C_FETCH;
                if (i_reg >= len_x)
                begin
                    // unclosed bracket stands for itself
                    dcount_next = dbase_reg;
                    emit_en     = 1'b1;
                    emit_lit    = CH_LBRACK;
                    p_next      = cs_reg + IW'(1);
                    base_next   = cs_reg + IW'(1);
                    ret_next    = C_TOK;
                end
                else if ((w0_reg == CH_RBRACK) && !first_reg)
                begin
                    emit_en   = 1'b1;
                    emit_kind = KIND_CLASS;
                    emit_neg  = neg_reg;
                    p_next    = i_reg + IW'(1);
                    base_next = i_reg + IW'(1);
                    ret_next  = C_TOK;
                end
                else
                begin
                    first_next  = 1'b0;
                    desc_en     = 1'b1;
                    dcount_next = dcount_reg + LW'(1);
                    ret_next    = C_CLS;
                    if (((i_reg + IW'(2)) < len_x) && (w1_reg == CH_DASH)
                        && (w2_reg != CH_RBRACK))
                    begin
                        desc_hi   = w2_reg;
                        i_next    = i_reg + IW'(3);
                        base_next = i_reg + IW'(3);
                    end
                    else
                    begin
                        i_next    = i_reg + IW'(1);
                        base_next = i_reg + IW'(1);
                    end
                end
            end
            C_SWEEP:
            begin
                c_next = c_reg + 8'd1;
                if (c_reg == 8'hFF)
                begin
                    done       = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
        if (emit_en)
        begin
            count_next = count_reg + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_FETCH)
        begin
            case (fcnt_reg)
                2'd1:    w0_reg <= rdata;
                2'd2:    w1_reg <= rdata;
                2'd3:    w2_reg <= rdata;
                default: w0_reg <= w0_reg;
            endcase
        end
        if (emit_en)
        begin
            kind_reg[count_reg[AW-1:0]] <= emit_kind;
            lit_reg[count_reg[AW-1:0]]  <= emit_lit;
            negm_reg[count_reg[AW-1:0]] <= emit_neg;
        end
        if (desc_en)
        begin
            dlo_reg[dcount_reg[AW-1:0]]  <= desc_lo;
            dhi_reg[dcount_reg[AW-1:0]]  <= desc_hi;
            down_reg[dcount_reg[AW-1:0]] <= count_reg[AW-1:0];
        end
        base_reg   <= base_next;
        fcnt_reg   <= fcnt_next;
        p_reg      <= p_next;
        i_reg      <= i_next;
        cs_reg     <= cs_next;
        neg_reg    <= neg_next;
        first_reg  <= first_next;
        dbase_reg  <= dbase_next;
        dcount_reg <= dcount_next;
        c_reg      <= c_next;
        ret_reg    <= ret_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign status.busy = (state_reg != C_IDLE);
    assign status.done = done;
    assign tok_kind    = kind_reg;
    assign tok_lit     = lit_reg;
    assign tok_count   = count_reg;
    assign cls_we      = (state_reg == C_SWEEP);
    assign cls_waddr   = c_reg;
    assign cls_wdata   = word ^ negm_vec;

endmodule

// ===== hdl/gsm_back.sv =====
// ----------------------------------------------------------------------------
// gsm_back
// executes queued commands: pattern store, position set update, result
// ----------------------------------------------------------------------------
module gsm_back
    import gsm_pkg::*;
#(
    parameter int PM = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  item_t                   head,
    input  logic                    head_valid,
    output logic                    pop,
    output logic                    cmp_start,
    input  cmp_status_t             cmp_status,
    output logic [$clog2(PM+1)-1:0] length,
    output logic                    pat_we,
    output logic [$clog2(PM)-1:0]   pat_waddr,
    output logic [7:0]              pat_wdata,
    input  kind_t                   tok_kind [PM],
    input  logic [7:0]              tok_lit [PM],
    input  logic [$clog2(PM+1)-1:0] tok_count,
    input  logic                    cls_we,
    input  logic [7:0]              cls_waddr,
    input  logic [PM-1:0]           cls_wdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata
);

    localparam int AW = $clog2(PM);
    localparam int LW = $clog2(PM+1);

    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          stale_reg, stale_next;
    logic          busy_reg, busy_next;
    logic          s2_v_reg, s2_v_next;
    cmd_t          s2_cmd_reg;
    logic [7:0]    s2_byte_reg;
    logic          s2_ovf_reg;
    logic [PM-1:0] act_reg, act_next;
    logic          acc_reg, acc_next;
    logic          out_v_reg, out_v_next;
    logic [1:0]    out_d_reg;

    logic          is_name, need_cmp, s2_adv, slot_free;
    logic [PM-1:0] word;
    logic [PM:0]   vm_w;
    logic [PM-1:0] vm, last, star, hit, step_a;
    logic          step_acc;
    logic [PM:0]   step_res, init_res;

    function automatic logic [PM:0] close_stars(input logic [PM-1:0] a,
                                                input logic [PM-1:0] s,
                                                input logic [PM-1:0] lst,
                                                input logic [PM-1:0] msk);
        logic [PM-1:0] g;
        logic [PM:0]   sum;
        logic [PM:0]   cy;
        logic [PM-1:0] y;
        g   = a & s;
        // carry chain runs an active bit through every run of stars
        sum = {1'b0, s} + {1'b0, g};
        cy  = sum ^ {1'b0, s} ^ {1'b0, g};
        y   = (a | cy[PM-1:0]) & msk;
        return {|(y & s & lst), y};
    endfunction

    gsm_ram #(.WIDTH(PM), .DEPTH(256)) u_cls_ram (
        .clk   (clk),
        .we    (cls_we),
        .waddr (cls_waddr),
        .wdata (cls_wdata),
        .raddr (head.value),
        .rdata (word)
    );

    assign is_name   = (head.cmd == CMD_NAME) || (head.cmd == CMD_END);
    assign need_cmp  = head_valid && is_name && stale_reg;
    assign s2_adv    = s2_v_reg && ((s2_cmd_reg != CMD_END) || !out_v_reg || m_axis_tready);
    assign slot_free = !s2_v_reg || s2_adv;
    assign pop       = head_valid && !busy_reg && !need_cmp && slot_free;
    assign cmp_start = need_cmp && !busy_reg && !s2_v_reg;

    assign length    = len_reg;
    assign pat_we    = pop && (head.cmd == CMD_APPEND) && (len_reg < LW'(PM));
    assign pat_waddr = len_reg[AW-1:0];
    assign pat_wdata = head.value;

    always_comb
    begin
        vm_w = ({{PM{1'b0}}, 1'b1} << tok_count) - {{PM{1'b0}}, 1'b1};
        vm   = vm_w[PM-1:0];
        last = vm ^ (vm >> 1);
        for (int t = 0; t < PM; t++)
        begin
            star[t] = (tok_kind[t] == KIND_STAR);
            case (tok_kind[t])
                KIND_LITERAL: hit[t] = (tok_lit[t] == s2_byte_reg);
                KIND_ANY:     hit[t] = 1'b1;
                KIND_CLASS:   hit[t] = word[t];
                default:      hit[t] = 1'b0;
            endcase
        end
        step_a   = ((act_reg & star) | ((act_reg & ~star & hit) << 1)) & vm;
        step_acc = |(act_reg & ~star & hit & last);
        step_res = close_stars(step_a, star & vm, last, vm);
        init_res = close_stars({{(PM-1){1'b0}}, (tok_count != '0)}, star & vm, last, vm);
    end

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        stale_next = stale_reg;
        busy_next  = busy_reg;
        act_next   = act_reg;
        acc_next   = acc_reg;
        out_v_next = out_v_reg && !m_axis_tready;
        s2_v_next  = (pop && is_name) || (s2_v_reg && !s2_adv);
        if (cmp_start)
        begin
            busy_next = 1'b1;
        end
        if (cmp_status.done)
        begin
            busy_next  = 1'b0;
            stale_next = 1'b0;
            act_next   = init_res[PM-1:0];
            acc_next   = init_res[PM] || (tok_count == '0);
        end
        if (pop)
        begin
            case (head.cmd)
                CMD_START:
                begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    stale_next = 1'b1;
                end
                CMD_APPEND:
                begin
                    stale_next = 1'b1;
                    if (len_reg < LW'(PM))
                    begin
                        len_next = len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    stale_next = stale_reg;
                end
            endcase
        end
        if (s2_adv)
        begin
            if (s2_cmd_reg == CMD_END)
            begin
                out_v_next = 1'b1;
                act_next   = init_res[PM-1:0];
                acc_next   = init_res[PM] || (tok_count == '0);
            end
            else
            begin
                act_next = step_res[PM-1:0];
                acc_next = step_acc || step_res[PM];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_name)
        begin
            s2_cmd_reg  <= head.cmd;
            s2_byte_reg <= head.value;
            s2_ovf_reg  <= ovf_reg;
        end
        if (s2_adv && (s2_cmd_reg == CMD_END))
        begin
            out_d_reg <= {s2_ovf_reg, acc_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            stale_reg <= 1'b0;
            busy_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            act_reg   <= {{(PM-1){1'b0}}, 1'b1};
            acc_reg   <= 1'b1;
            out_v_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            stale_reg <= stale_next;
            busy_reg  <= busy_next;
            s2_v_reg  <= s2_v_next;
            act_reg   <= act_next;
            acc_reg   <= acc_next;
            out_v_reg <= out_v_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {6'd0, out_d_reg};

    a_start_when_stale: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_start |-> stale_reg && !s2_v_reg)
        else $error("compile started without a pattern change");

    a_no_pop_in_compile: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !pop)
        else $error("queue popped while compiling");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && (s2_cmd_reg == CMD_END)) |=> out_v_reg)
        else $error("end of name lost its result");

    a_name_after_compile: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_name) |-> !stale_reg)
        else $error("name byte executed against stale tokens");

endmodule

// ===== verif/glob_segment_matcher_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_segment_matcher_chk
// watches both channels, predicts each match result and compares it
// ----------------------------------------------------------------------------
module glob_segment_matcher_chk
    import gsm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic [7:0]  pat_mem [64];
    int          pat_len;
    logic        ovf_seen;
    kind_t       tok_kind [64];
    logic [7:0]  tok_lit [64];
    logic [63:0] cls_mask [256];
    int          tok_cnt;
    logic        stale;
    logic [63:0] live;
    logic        live_accept;
    verdict_t    verdict_q [$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void close_stars();
        for (int t = 0; t < tok_cnt; t++)
        begin
            if (live[t] && tok_kind[t] == KIND_STAR)
            begin
                if (t + 1 < tok_cnt) live[t + 1] = 1'b1;
                else live_accept = 1'b1;
            end
        end
    endfunction

    function automatic void restart_name();
        live = (tok_cnt > 0) ? 64'd1 : 64'd0;
        live_accept = (tok_cnt == 0);
        close_stars();
    endfunction

    function automatic void build_tokens();
        int n, p, cnt, i;
        logic [255:0] mem;
        logic neg, first, closed;
        n = pat_len;
        p = 0;
        cnt = 0;
        for (int c = 0; c < 256; c++) cls_mask[c] = '0;
        while (p < n && cnt < 64)
        begin
            if (pat_mem[p] == CH_STAR)
            begin
                tok_kind[cnt] = KIND_STAR;
                p++;
            end
            else if (pat_mem[p] == CH_QUEST)
            begin
                tok_kind[cnt] = KIND_ANY;
                p++;
            end
            else if (pat_mem[p] == CH_LBRACK)
            begin
                mem = '0;
                neg = 0;
                first = 1;
                closed = 0;
                i = p + 1;
                if (i < n && (pat_mem[i] == CH_BANG || pat_mem[i] == CH_CARET))
                begin
                    neg = 1;
                    i++;
                end
                while (i < n)
                begin
                    if (pat_mem[i] == CH_RBRACK && !first)
                    begin
                        closed = 1;
                        i++;
                        break;
                    end
                    first = 0;
                    if (i + 2 < n && pat_mem[i + 1] == CH_DASH
                            && pat_mem[i + 2] != CH_RBRACK)
                    begin
                        for (int c = pat_mem[i]; c <= pat_mem[i + 2]; c++) mem[c] = 1;
                        i += 3;
                    end
                    else
                    begin
                        mem[pat_mem[i]] = 1;
                        i++;
                    end
                end
                if (closed)
                begin
                    tok_kind[cnt] = KIND_CLASS;
                    for (int c = 0; c < 256; c++)
                        if (mem[c] ^ neg) cls_mask[c][cnt] = 1'b1;
                    p = i;
                end
                else
                begin
                    tok_kind[cnt] = KIND_LITERAL;
                    tok_lit[cnt] = CH_LBRACK;
                    p++;
                end
            end
            else
            begin
                tok_kind[cnt] = KIND_LITERAL;
                tok_lit[cnt] = pat_mem[p];
                p++;
            end
            cnt++;
        end
        tok_cnt = cnt;
        stale = 0;
        restart_name();
    endfunction

    function automatic void step_name(input logic [7:0] b);
        logic [63:0] nxt;
        logic nacc, ok;
        nxt = '0;
        nacc = 0;
        for (int t = 0; t < tok_cnt; t++)
        begin
            if (!live[t]) continue;
            case (tok_kind[t])
                KIND_STAR:
                begin
                    nxt[t] = 1'b1;
                    ok = 0;
                end
                KIND_LITERAL: ok = (tok_lit[t] == b);
                KIND_ANY:     ok = 1;
                default:      ok = cls_mask[b][t];
            endcase
            if (ok)
            begin
                if (t + 1 < tok_cnt) nxt[t + 1] = 1'b1;
                else nacc = 1'b1;
            end
        end
        live = nxt;
        live_accept = nacc;
        close_stars();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got, exp;
        if (!rst_n)
        begin
            pat_len = 0;
            ovf_seen = 0;
            tok_cnt = 0;
            stale = 0;
            live = 64'd1;
            live_accept = 1;
            verdict_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (cmd_t'(s_axis_tuser))
                    CMD_START:
                    begin
                        pat_len = 0;
                        ovf_seen = 0;
                        stale = 1;
                    end
                    CMD_APPEND:
                    begin
                        if (pat_len < PATTERN_MAX)
                        begin
                            pat_mem[pat_len] = s_axis_tdata;
                            pat_len++;
                        end
                        else ovf_seen = 1;
                        stale = 1;
                    end
                    CMD_NAME:
                    begin
                        if (stale) build_tokens();
                        step_name(s_axis_tdata);
                    end
                    default:
                    begin
                        if (stale) build_tokens();
                        verdict_q = {verdict_q, verdict_t'({live_accept, ovf_seen})};
                        restart_name();
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = verdict_t'({m_axis_tdata[0], m_axis_tdata[1]});
                if (verdict_q.size() == 0) report("result with none expected");
                else
                begin
                    exp = verdict_q.pop_front();
                    if (got.matched !== exp.matched)
                        report($sformatf("matched %b, want %b", got.matched, exp.matched));
                    if (got.overflow !== exp.overflow)
                        report($sformatf("overflow %b, want %b", got.overflow,
                                         exp.overflow));
                end
            end
            pending = verdict_q.size();
        end
    end

endmodule

// ===== verif/glob_segment_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_segment_matcher_tb
// drives patterns and names with random gaps and stalls, checker compares
// ----------------------------------------------------------------------------
module glob_segment_matcher_tb;
    import gsm_pkg::*;

    localparam int WATCHDOG = 200000;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // byte_value
    logic [1:0] s_axis_tuser;   // command
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // matched, pattern_overflow, zero pad
    int         fail_count;
    int         pending;
    int         idle_cycles;
    bit         calm;
    bit         hold_sink;

    glob_segment_matcher dut (.*);

    glob_segment_matcher_chk chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // valid stays high between back to back transactions
    task automatic send(input cmd_t c, input logic [7:0] v);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic load_pattern(input string s);
        send(CMD_START, 8'($urandom));
        foreach (s[i]) send(CMD_APPEND, s[i]);
    endtask

    task automatic test_name(input string s);
        foreach (s[i]) send(CMD_NAME, s[i]);
        send(CMD_END, 8'($urandom));
    endtask

    function automatic logic [7:0] rand_sym();
        case ($urandom_range(0, 11))
            0: return CH_STAR;
            1: return CH_QUEST;
            2: return CH_LBRACK;
            3: return CH_RBRACK;
            4: return CH_BANG;
            5: return CH_CARET;
            6: return CH_DASH;
            7: return 8'($urandom);
            default: return 8'h61 + 8'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [7:0] rand_name_byte();
        if ($urandom_range(0, 5) == 0) return 8'($urandom);
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    // sink: random stalls, one long hold early in the run
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int n_items, len;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = CMD_START;
        calm = 0;
        hold_sink = 0;
        n_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty pattern, then extremes of name bytes
        test_name("");
        test_name("a");
        load_pattern("a*[!b-d]?");
        test_name("aXcz");
        test_name("azzez");
        send(CMD_NAME, 8'hFF);
        send(CMD_NAME, 8'h00);
        // pattern change mid-name discards the partial name
        load_pattern("[]a-]x[^z-a][");
        test_name("]x[[");
        test_name("-xq[");
        load_pattern("[\x80-\xff]*");
        send(CMD_NAME, 8'hFF);
        send(CMD_END, 8'h00);

        // many short names behind a blocked sink
        hold_sink = 1;
        repeat (20) test_name("");

        while (n_items < 700)
        begin
            if (n_items > 600) calm = 1;
            if ($urandom_range(0, 3) == 0)
            begin
                // random pattern, sometimes past capacity
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 8);
                send(CMD_START, 8'($urandom));
                for (int i = 0; i < len; i++) send(CMD_APPEND, rand_sym());
                n_items += len + 1;
            end
            repeat ($urandom_range(1, 4))
            begin
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) send(CMD_NAME, rand_name_byte());
                send(CMD_END, 8'($urandom));
                n_items += len + 1;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
